// ===== hdl/wfir_pkg.sv =====
// Shared types and constants of the ten-tap symmetric FIR filter.
package wfir_pkg;

    localparam int TAPS       = 10;
    localparam int NUM_COEFS  = 5;
    localparam int COEF_W     = 16;
    localparam int OUT_W      = 16;
    localparam int TAP_IDX_W  = 4;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_BITS  = 15;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [TAP_IDX_W-1:0]     t_tap_idx;
    typedef logic [COEF_IDX_W-1:0]    t_coef_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_OUTER  = 3'd0,
        CFG_COEF_SECOND = 3'd1,
        CFG_COEF_THIRD  = 3'd2,
        CFG_COEF_FOURTH = 3'd3,
        CFG_COEF_CENTER = 3'd4
    } t_cfg_idx;

    localparam t_coef COEF_RESET [NUM_COEFS] = '{
        -16'sd78, -16'sd430, -16'sd1071, 16'sd3002, 16'sd11558
    };

endpackage

// ===== hdl/windowed_fir_filter.sv =====
// Top level of the ten-tap symmetric FIR filter with a RAM-held delay line.
// The ten taps are read one after another through the single read port of the
// delay-line RAM and pass through the read and multiply pipeline; a new sample
// is accepted only once the result of the previous one has been registered.
// Reset clears the delay line at once through per-slot valid bits, returns the
// write position to slot zero and loads the Hamming-windowed default coefficients.
module windowed_fir_filter #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [wfir_pkg::OUT_W-1:0]   o_filtered,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wfir_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wfir_pkg::COEF_W-1:0]         i_cfg_data
);

    import wfir_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
    localparam int ACC_W  = PROD_W + 4;
    localparam int SHR_W  = ACC_W - FRAC_BITS;
    localparam int SAT_W  = (SHR_W > OUT_W) ? SHR_W : OUT_W + 1;
    localparam int ADDR_W = $clog2(TAPS);

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SAT_W-1:0] SAT_MAX    = SAT_W'(32767);
    localparam logic signed [SAT_W-1:0] SAT_MIN    = -SAT_W'(32768);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_state                    r_state;
    t_coef                     r_coef [NUM_COEFS];
    logic [TAPS-1:0]           r_slot_ok;
    logic [ADDR_W-1:0]         r_wpos;
    logic [ADDR_W-1:0]         r_rptr;
    t_tap_idx                  r_k;
    logic                      r_rd_vld;
    logic                      r_rd_live;
    t_coef                     r_rd_coef;
    logic                      r_prod_vld;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic signed [OUT_W-1:0]   r_filtered;

    logic                      w_accept;
    logic [SAMPLE_BITS-1:0]    w_rd_data;
    logic [SAMPLE_BITS-1:0]    w_rd_sample;
    t_tap_idx                  w_tap_rev;
    t_coef_idx                 w_coef_idx;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_biased;
    logic signed [SHR_W-1:0]   w_shifted;
    logic signed [SAT_W-1:0]   w_wide;
    logic signed [OUT_W-1:0]   w_result;
    logic                      w_finish;

    assign w_accept    = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_filtered  = r_filtered;

    wfir_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wpos),
        .i_wdata (i_sample),
        .i_raddr (r_rptr),
        .o_rdata (w_rd_data)
    );

    // Taps are symmetric about the centre, so the second half mirrors the first.
    assign w_tap_rev  = t_tap_idx'(TAPS - 1) - r_k;
    assign w_coef_idx = (r_k < t_tap_idx'(NUM_COEFS)) ? r_k[COEF_IDX_W-1:0]
                                                      : w_tap_rev[COEF_IDX_W-1:0];

    assign w_rd_sample = r_rd_live ? w_rd_data : '0;
    assign w_prod      = $signed({1'b0, w_rd_sample}) * r_rd_coef;

    assign w_biased  = r_acc + ROUND_BIAS;
    assign w_shifted = w_biased[ACC_W-1:FRAC_BITS];
    assign w_wide    = SAT_W'(w_shifted);

    always_comb begin
        if (w_wide > SAT_MAX) begin
            w_result = 16'sh7FFF;
        end else if (w_wide < SAT_MIN) begin
            w_result = 16'sh8000;
        end else begin
            w_result = w_wide[OUT_W-1:0];
        end
    end

    assign w_finish = (r_state == S_DRAIN) && !r_rd_vld && !r_prod_vld
                      && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_COEF_CENTER)) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_coef <= r_coef[w_coef_idx];
        r_prod    <= w_prod;
        if (w_finish) begin
            r_filtered <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot_ok   <= '0;
            r_wpos      <= '0;
            r_rptr      <= '0;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_live   <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld   <= (r_state == S_ISSUE);
            r_prod_vld <= r_rd_vld;
            if (w_accept) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_slot_ok[r_wpos] <= 1'b1;
                        r_rptr            <= r_wpos;
                        r_wpos            <= (r_wpos == ADDR_W'(TAPS - 1)) ? '0
                                                                           : r_wpos + 1'b1;
                        r_k               <= '0;
                        r_state           <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_rd_live <= r_slot_ok[r_rptr];
                    r_rptr    <= (r_rptr == '0) ? ADDR_W'(TAPS - 1) : r_rptr - 1'b1;
                    r_k       <= r_k + 1'b1;
                    if (r_k == t_tap_idx'(TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/wfir_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module wfir_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/sv/windowed_fir_filter_tb.sv =====
// Self-checking testbench of the ten-tap windowed FIR filter.
`timescale 1ns / 1ps

module windowed_fir_filter_tb;
    import wfir_pkg::*;

    localparam int SAMPLE_BITS = 10;
    localparam int IDLE_PCT    = 29;
    localparam int N_PHASES    = 6;
    localparam int PHASE_LEN   = 125;
    localparam int DRAIN_PAUSE = 20;
    localparam int CYCLE_LIMIT = 400_000;
    localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) << (OUT_W - 1));

    localparam logic [COEF_W-1:0]      COEF_MIN      = 16'h8000;
    localparam logic [COEF_W-1:0]      COEF_MAX      = 16'h7FFF;
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX       = '1;
    localparam logic [CFG_IDX_W-1:0]   CFG_IDX_SPARE = CFG_IDX_W'(NUM_COEFS);
    localparam logic [CFG_IDX_W-1:0]   CFG_IDX_TOP   = '1;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [COEF_W-1:0]        data;
        logic [SAMPLE_BITS-1:0]   smp;
        logic                     chk;
        logic signed [OUT_W-1:0]  expv;
    } t_dir_row;

    localparam int N_DIR = 39;

    t_dir_row dir_tab [N_DIR] = '{
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, 10'd0,   1'b1, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, 10'd512, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, 10'd1,   1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, 10'h2AA, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, 10'h155, 1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_OUTER,  COEF_MIN, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_SECOND, COEF_MIN, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_THIRD,  COEF_MIN, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_FOURTH, COEF_MIN, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_CENTER, COEF_MIN, 10'd0,   1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b1, -16'sd10230},
        '{ROW_CFG,    CFG_COEF_OUTER,  COEF_MAX, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_SECOND, COEF_MAX, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_THIRD,  COEF_MAX, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_FOURTH, COEF_MAX, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_CENTER, COEF_MAX, 10'd0,   1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b1, 16'sd10230},
        '{ROW_CFG,    CFG_IDX_SPARE,   16'h0000, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_IDX_TOP,     COEF_MIN, 10'd0,   1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b1, 16'sd10230},
        '{ROW_CFG,    CFG_COEF_OUTER,  16'h0001, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_SECOND, 16'hFFFF, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_THIRD,  16'h4000, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_FOURTH, 16'hC000, 10'd0,   1'b0, 16'sd0},
        '{ROW_CFG,    CFG_COEF_CENTER, 16'h0000, 10'd0,   1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, 10'd0,   1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, 10'd5,   1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_COEF_OUTER,  16'h0000, SMP_MAX, 1'b0, 16'sd0}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [SAMPLE_BITS-1:0]        i_sample;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [OUT_W-1:0]       o_filtered;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [COEF_W-1:0]             i_cfg_data;

    logic [SAMPLE_BITS-1:0]        tap_hist [TAPS];
    t_tap_idx                      wr_slot;
    t_coef                         coef_reg [NUM_COEFS];
    logic signed [OUT_W-1:0]       filtered_q [$];

    logic                          pinned;
    logic signed [OUT_W-1:0]       pinned_val;
    int                            idle_pct;
    int                            cycle_cnt;
    int                            mismatch_cnt;
    int                            n_samples;
    int                            n_checked;
    int                            n_cfg;
    int                            n_cfg_spare;

    windowed_fir_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_filtered  (o_filtered),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [OUT_W-1:0] fir_predict(input logic [SAMPLE_BITS-1:0] s);
        longint acc;
        longint rnd;
        int     slot;
        int     m;
        acc = 0;
        tap_hist[wr_slot] = s;
        for (int k = 0; k < TAPS; k++) begin
            slot = (int'(wr_slot) + TAPS - k) % TAPS;
            m    = (k < TAPS / 2) ? k : TAPS - 1 - k;
            acc += longint'(tap_hist[slot]) * longint'(coef_reg[m]);
        end
        rnd = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (rnd > OUT_MAX) rnd = OUT_MAX;
        if (rnd < OUT_MIN) rnd = OUT_MIN;
        wr_slot = (int'(wr_slot) == TAPS - 1) ? '0 : wr_slot + 1'b1;
        return rnd[OUT_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic drive_sample(input logic [SAMPLE_BITS-1:0] s, input logic pin,
                                input logic signed [OUT_W-1:0] pin_val);
        int gap;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pinned     = pin;
        pinned_val = pin_val;
        i_valid   <= 1'b1;
        i_sample  <= s;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Lowers both request lines, lets every outstanding beat drain, then allows for latency.
    task automatic quiesce();
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (filtered_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] pred;
        logic signed [OUT_W-1:0] want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) tap_hist[i] = '0;
            for (int i = 0; i < NUM_COEFS; i++) coef_reg[i] = COEF_RESET[i];
            wr_slot = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg++;
                if (i_cfg_index < NUM_COEFS) coef_reg[i_cfg_index] = t_coef'(i_cfg_data);
                else n_cfg_spare++;
            end
            if (i_valid && o_ready) begin
                n_samples++;
                pred = fir_predict(i_sample);
                filtered_q.push_back(pinned ? pinned_val : pred);
            end
            if (o_valid === 1'b1 && i_ready) begin
                if (filtered_q.size() == 0) begin
                    flag_mismatch($sformatf("filtered %0d with no sample outstanding",
                                            o_filtered));
                end else begin
                    want = filtered_q.pop_front();
                    n_checked++;
                    if (o_filtered !== want) begin
                        flag_mismatch($sformatf("filtered %0d, expected %0d", o_filtered, want));
                    end
                end
            end
        end
    end

    initial begin
        logic [SAMPLE_BITS-1:0] s;
        logic [COEF_W-1:0]      cv;
        int                     pick;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_sample     <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_COEF_OUTER;
        i_cfg_data   <= '0;
        pinned       = 1'b0;
        pinned_val   = '0;
        idle_pct     = IDLE_PCT;
        cycle_cnt    = 0;
        mismatch_cnt = 0;
        n_samples    = 0;
        n_checked    = 0;
        n_cfg        = 0;
        n_cfg_spare  = 0;
        s            = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                if (r == 0 || dir_tab[r-1].kind != ROW_CFG) quiesce();
                cfg_write(dir_tab[r].idx, dir_tab[r].data);
            end else begin
                if (r != 0 && dir_tab[r-1].kind == ROW_CFG) quiesce();
                drive_sample(dir_tab[r].smp, dir_tab[r].chk, dir_tab[r].expv);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            quiesce();
            idle_pct = IDLE_PCT;
            for (int c = 0; c < NUM_COEFS; c++) begin
                pick = $urandom_range(99);
                if (ph == 0)        cv = COEF_RESET[c];
                else if (pick < 15) cv = COEF_MIN;
                else if (pick < 30) cv = COEF_MAX;
                else if (pick < 40) cv = '0;
                else                cv = COEF_W'($urandom);
                cfg_write(CFG_IDX_W'(c), cv);
            end
            if ($urandom_range(1) == 1) begin
                cfg_write(CFG_IDX_W'($urandom_range(CFG_IDX_TOP, CFG_IDX_SPARE)),
                          COEF_W'($urandom));
            end
            quiesce();
            // The third phase runs with both sides permanently ready.
            idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(99);
                if (pick < 10)      s = '0;
                else if (pick < 20) s = SMP_MAX;
                else if (pick >= 30) s = SAMPLE_BITS'($urandom);
                drive_sample(s, 1'b0, '0);
            end
        end

        quiesce();
        $display("Drove %0d samples through the filter and checked %0d outputs.",
                 n_samples, n_checked);
        $display("Made %0d coefficient writes, %0d of them to unused indexes.",
                 n_cfg, n_cfg_spare);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
